/* hdl/c8core_pkg.sv */
package c8core_pkg;

    // machine geometry
    localparam int ADDR_W      = 12;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int ROWS        = 32;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int COLS        = 64;
    localparam int COL_W       = $clog2(COLS);
    localparam int FONT_LEN    = 80;

    localparam logic [ADDR_W-1:0] PROG_START = 12'h200;

    // input commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EXEC  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_PIXEL = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_WAIT    = 2'd2;

    // datapath steps issued by the controller
    localparam logic [4:0] ST_NONE     = 5'd0;
    localparam logic [4:0] ST_CLEAR    = 5'd1;
    localparam logic [4:0] ST_WRITE    = 5'd2;
    localparam logic [4:0] ST_TICK     = 5'd3;
    localparam logic [4:0] ST_PIXRD    = 5'd4;
    localparam logic [4:0] ST_PIXSEL   = 5'd5;
    localparam logic [4:0] ST_FETCH_HI = 5'd6;
    localparam logic [4:0] ST_FETCH_LO = 5'd7;
    localparam logic [4:0] ST_OPLAT    = 5'd8;
    localparam logic [4:0] ST_REGRD    = 5'd9;
    localparam logic [4:0] ST_EXEC     = 5'd10;
    localparam logic [4:0] ST_ALUWB    = 5'd11;
    localparam logic [4:0] ST_DRAW_RD  = 5'd12;
    localparam logic [4:0] ST_DRAW_WR  = 5'd13;
    localparam logic [4:0] ST_DRAW_END = 5'd14;
    localparam logic [4:0] ST_BCD      = 5'd15;
    localparam logic [4:0] ST_STR_RD   = 5'd16;
    localparam logic [4:0] ST_STR_WR   = 5'd17;
    localparam logic [4:0] ST_LDR_RD   = 5'd18;
    localparam logic [4:0] ST_LDR_WR   = 5'd19;
    localparam logic [4:0] ST_RESULT   = 5'd20;

    // instruction classes for sequencing
    localparam logic [2:0] OPC_SIMPLE = 3'd0;
    localparam logic [2:0] OPC_ALUF   = 3'd1;
    localparam logic [2:0] OPC_DRAW   = 3'd2;
    localparam logic [2:0] OPC_BCD    = 3'd3;
    localparam logic [2:0] OPC_STORE  = 3'd4;
    localparam logic [2:0] OPC_LOAD   = 3'd5;

    typedef struct packed {
        logic       latch;
        logic [4:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] op_class;
        logic       draw_empty;
        logic       cnt_last;
        logic       clr_last;
    } dp_stat_t;

    localparam logic [7:0] FONT [FONT_LEN] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

/* hdl/chip8_instruction_core.sv */
// channel  | handshake          | payload
// in       | in_valid/in_ready  | command, address, data, keys_down, last_key, random_byte
// out      | out_valid/out_ready| status, program_counter, pixel_value, screen_drawn, sound_active
//
// one item at a time. instructions fetch two bytes, read registers and execute;
// draw, bcd and block load/store then loop over rows, digits or registers 0 to x.
// the loops run on the main memory and register file ports, one write port each.
// after reset a clearing pass over all 4096 addresses loads the font and zeros
// memory; in_ready stays low during it. a result waiting in the output register
// holds back the next item's result until it is taken.
module chip8_instruction_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [11:0] address,
    input  logic [7:0]  data,
    input  logic [15:0] keys_down,
    input  logic [3:0]  last_key,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [11:0] program_counter,
    output logic        pixel_value,
    output logic        screen_drawn,
    output logic        sound_active
);

    c8core_pkg::dp_cmd_t  dp_cmd;
    c8core_pkg::dp_stat_t dp_stat;

    // sequencing
    c8core_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // state, memories and execution
    c8core_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .command         (command),
        .address         (address),
        .data            (data),
        .keys_down       (keys_down),
        .last_key        (last_key),
        .random_byte     (random_byte),
        .status          (status),
        .program_counter (program_counter),
        .pixel_value     (pixel_value),
        .screen_drawn    (screen_drawn),
        .sound_active    (sound_active)
    );

endmodule

/* hdl/c8core_controller.sv */
module c8core_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  c8core_pkg::dp_stat_t stat,
    output c8core_pkg::dp_cmd_t  cmd
);

    localparam logic [4:0] C_CLEAR = 5'd0;
    localparam logic [4:0] C_IDLE  = 5'd1;
    localparam logic [4:0] C_DISP  = 5'd2;
    localparam logic [4:0] C_PIX   = 5'd3;
    localparam logic [4:0] C_F1    = 5'd4;
    localparam logic [4:0] C_F2    = 5'd5;
    localparam logic [4:0] C_RR    = 5'd6;
    localparam logic [4:0] C_EX    = 5'd7;
    localparam logic [4:0] C_WB    = 5'd8;
    localparam logic [4:0] C_DRD   = 5'd9;
    localparam logic [4:0] C_DWR   = 5'd10;
    localparam logic [4:0] C_DEND  = 5'd11;
    localparam logic [4:0] C_BCD   = 5'd12;
    localparam logic [4:0] C_SRD   = 5'd13;
    localparam logic [4:0] C_SWR   = 5'd14;
    localparam logic [4:0] C_LRD   = 5'd15;
    localparam logic [4:0] C_LWR   = 5'd16;
    localparam logic [4:0] C_OUT   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == C_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state and step selection
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.latch      = accept;
        cmd.step       = c8core_pkg::ST_NONE;
        unique case (state_reg)
            C_CLEAR:
            begin
                cmd.step = c8core_pkg::ST_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = C_IDLE;
                end
            end
            C_IDLE:
            begin
                if (accept)
                begin
                    state_next = C_DISP;
                end
            end
            C_DISP:
            begin
                unique case (stat.cmd)
                    c8core_pkg::CMD_WRITE:
                    begin
                        cmd.step   = c8core_pkg::ST_WRITE;
                        state_next = C_OUT;
                    end
                    c8core_pkg::CMD_TICK:
                    begin
                        cmd.step   = c8core_pkg::ST_TICK;
                        state_next = C_OUT;
                    end
                    c8core_pkg::CMD_PIXEL:
                    begin
                        cmd.step   = c8core_pkg::ST_PIXRD;
                        state_next = C_PIX;
                    end
                    default:
                    begin
                        cmd.step   = c8core_pkg::ST_FETCH_HI;
                        state_next = C_F1;
                    end
                endcase
            end
            C_PIX:
            begin
                cmd.step   = c8core_pkg::ST_PIXSEL;
                state_next = C_OUT;
            end
            C_F1:
            begin
                cmd.step   = c8core_pkg::ST_FETCH_LO;
                state_next = C_F2;
            end
            C_F2:
            begin
                cmd.step   = c8core_pkg::ST_OPLAT;
                state_next = C_RR;
            end
            C_RR:
            begin
                cmd.step   = c8core_pkg::ST_REGRD;
                state_next = C_EX;
            end
            C_EX:
            begin
                cmd.step = c8core_pkg::ST_EXEC;
                unique case (stat.op_class)
                    c8core_pkg::OPC_ALUF:  state_next = C_WB;
                    c8core_pkg::OPC_DRAW:  state_next = stat.draw_empty ? C_DEND : C_DRD;
                    c8core_pkg::OPC_BCD:   state_next = C_BCD;
                    c8core_pkg::OPC_STORE: state_next = C_SRD;
                    c8core_pkg::OPC_LOAD:  state_next = C_LRD;
                    default:               state_next = C_OUT;
                endcase
            end
            C_WB:
            begin
                cmd.step   = c8core_pkg::ST_ALUWB;
                state_next = C_OUT;
            end
            C_DRD:
            begin
                cmd.step   = c8core_pkg::ST_DRAW_RD;
                state_next = C_DWR;
            end
            C_DWR:
            begin
                cmd.step   = c8core_pkg::ST_DRAW_WR;
                state_next = stat.cnt_last ? C_DEND : C_DRD;
            end
            C_DEND:
            begin
                cmd.step   = c8core_pkg::ST_DRAW_END;
                state_next = C_OUT;
            end
            C_BCD:
            begin
                cmd.step = c8core_pkg::ST_BCD;
                if (stat.cnt_last)
                begin
                    state_next = C_OUT;
                end
            end
            C_SRD:
            begin
                cmd.step   = c8core_pkg::ST_STR_RD;
                state_next = C_SWR;
            end
            C_SWR:
            begin
                cmd.step   = c8core_pkg::ST_STR_WR;
                state_next = stat.cnt_last ? C_OUT : C_SRD;
            end
            C_LRD:
            begin
                cmd.step   = c8core_pkg::ST_LDR_RD;
                state_next = C_LWR;
            end
            C_LWR:
            begin
                cmd.step   = c8core_pkg::ST_LDR_WR;
                state_next = stat.cnt_last ? C_OUT : C_LRD;
            end
            C_OUT:
            begin
                if (out_free)
                begin
                    cmd.step       = c8core_pkg::ST_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/c8core_datapath.sv */
module c8core_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c8core_pkg::dp_cmd_t  cmd,
    output c8core_pkg::dp_stat_t stat,
    input  logic [1:0]           command,
    input  logic [11:0]          address,
    input  logic [7:0]           data,
    input  logic [15:0]          keys_down,
    input  logic [3:0]           last_key,
    input  logic [7:0]           random_byte,
    output logic [1:0]           status,
    output logic [11:0]          program_counter,
    output logic                 pixel_value,
    output logic                 screen_drawn,
    output logic                 sound_active
);

    // latched item
    logic [1:0]  cmd_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg;
    logic [15:0] keys_reg;
    logic [3:0]  last_reg;
    logic [7:0]  rnd_reg;

    // architectural state
    logic [11:0] pc_reg;
    logic [15:0] index_reg;
    logic [c8core_pkg::SP_W-1:0] sp_reg;
    logic [11:0] stack_reg [c8core_pkg::STACK_DEPTH];
    logic [7:0]  delay_reg;
    logic [7:0]  sound_reg;

    // instruction and working registers
    logic [15:0] op_reg;
    logic [7:0]  alu_res_reg;
    logic        flag_reg;
    logic [3:0]  cnt_reg;
    logic [11:0] clr_cnt_reg;
    logic [1:0]  sts_res_reg;
    logic        pix_res_reg;
    logic        drew_res_reg;

    // output register
    logic [1:0]  status_reg;
    logic [11:0] pc_out_reg;
    logic        pixel_reg;
    logic        drawn_reg;
    logic        sound_act_reg;

    // memories
    logic [7:0]  main_mem [4096];
    logic [7:0]  mem_rdata_reg;
    logic [7:0]  rf_mem [16];
    logic [15:0] rf_valid_reg;
    logic [7:0]  va_reg;
    logic [7:0]  vb_reg;
    logic [c8core_pkg::COLS-1:0] frame_mem [c8core_pkg::ROWS];
    logic [c8core_pkg::ROWS-1:0] fvalid_reg;
    logic [c8core_pkg::COLS-1:0] frow_reg;

    // decode fields
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [3:0]  hi;
    logic        op_invalid;
    logic [2:0]  op_class;
    logic        key_down;
    logic [11:0] pc2;
    logic [11:0] pc4;
    logic [11:0] pc_exec;
    logic [11:0] i_off;
    logic [c8core_pkg::SP_W-1:0] sp_dec;
    logic [c8core_pkg::SP_W-1:0] sp_inc;
    logic        cnt_last;

    assign x   = op_reg[11:8];
    assign y   = op_reg[7:4];
    assign n   = op_reg[3:0];
    assign kk  = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign hi  = op_reg[15:12];
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;
    assign i_off = index_reg[11:0] + {8'd0, cnt_reg};
    assign key_down = (va_reg[7:4] == 4'd0) && keys_reg[va_reg[3:0]];
    assign sp_dec = (sp_reg == '0) ? c8core_pkg::SP_W'(c8core_pkg::STACK_DEPTH - 1)
                                   : sp_reg - 1'b1;
    assign sp_inc = (sp_reg == c8core_pkg::SP_W'(c8core_pkg::STACK_DEPTH - 1)) ? '0
                                   : sp_reg + 1'b1;

    // invalid opcode and class decode
    always_comb
    begin
        op_invalid = 1'b0;
        op_class   = c8core_pkg::OPC_SIMPLE;
        unique case (hi)
            4'h0: op_invalid = !(op_reg == 16'h00E0 || op_reg == 16'h00EE);
            4'h8:
            begin
                if (n == 4'h4 || n == 4'h5 || n == 4'h6 || n == 4'h7 || n == 4'hE)
                begin
                    op_class = c8core_pkg::OPC_ALUF;
                end
                else if (n > 4'h3)
                begin
                    op_invalid = 1'b1;
                end
            end
            4'hD: op_class = c8core_pkg::OPC_DRAW;
            4'hE: op_invalid = !(kk == 8'h9E || kk == 8'hA1);
            4'hF:
            begin
                unique case (kk)
                    8'h33: op_class = c8core_pkg::OPC_BCD;
                    8'h55: op_class = c8core_pkg::OPC_STORE;
                    8'h65: op_class = c8core_pkg::OPC_LOAD;
                    8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29: op_invalid = 1'b0;
                    default: op_invalid = 1'b1;
                endcase
            end
            default: op_invalid = 1'b0;
        endcase
    end

    // next program counter of a valid instruction
    always_comb
    begin
        pc_exec = pc2;
        unique case (hi)
            4'h0:
            begin
                if (op_reg != 16'h00E0)
                begin
                    pc_exec = stack_reg[sp_dec];
                end
            end
            4'h1: pc_exec = nnn;
            4'h2: pc_exec = nnn;
            4'h3: if (va_reg == kk) pc_exec = pc4;
            4'h4: if (va_reg != kk) pc_exec = pc4;
            4'h5: if (va_reg == vb_reg) pc_exec = pc4;
            4'h9: if (va_reg != vb_reg) pc_exec = pc4;
            4'hB: pc_exec = nnn + {4'd0, va_reg};
            4'hE: if ((kk == 8'h9E) == key_down) pc_exec = pc4;
            4'hF: if (kk == 8'h0A && keys_reg == 16'd0) pc_exec = pc_reg;
            default: pc_exec = pc2;
        endcase
    end

    // alu for the flag-setting group
    logic [8:0] sum9;
    logic [7:0] alu_res;
    logic       alu_flag;

    assign sum9 = {1'b0, va_reg} + {1'b0, vb_reg};

    always_comb
    begin
        alu_res  = 8'd0;
        alu_flag = 1'b0;
        unique case (n)
            4'h4:
            begin
                alu_res  = sum9[7:0];
                alu_flag = sum9[8];
            end
            4'h5:
            begin
                alu_res  = va_reg - vb_reg;
                alu_flag = va_reg > vb_reg;
            end
            4'h6:
            begin
                alu_res  = {1'b0, va_reg[7:1]};
                alu_flag = va_reg[0];
            end
            4'h7:
            begin
                alu_res  = vb_reg - va_reg;
                alu_flag = vb_reg > va_reg;
            end
            default:
            begin
                alu_res  = {va_reg[6:0], 1'b0};
                alu_flag = va_reg[7];
            end
        endcase
    end

    // decimal digits of vx
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_mul;
    logic [3:0]  bcd_t;
    logic [3:0]  bcd_o;
    logic [7:0]  bcd_digit;

    always_comb
    begin
        if (va_reg >= 8'd200)
        begin
            bcd_h = 2'd2;
        end
        else if (va_reg >= 8'd100)
        begin
            bcd_h = 2'd1;
        end
        else
        begin
            bcd_h = 2'd0;
        end
        bcd_rem = 7'(va_reg - 8'(bcd_h) * 8'd100);
        bcd_mul = 15'(bcd_rem) * 15'd205;
        bcd_t   = bcd_mul[14:11];
        bcd_o   = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
        unique case (cnt_reg[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = {4'd0, bcd_o};
        endcase
    end

    // sprite row mask and collision
    logic [c8core_pkg::COLS-1:0]  spr_mask;
    logic [c8core_pkg::COL_W-1:0] col;
    logic [c8core_pkg::ROW_W-1:0] draw_row;
    logic                         collide;

    assign draw_row = vb_reg[c8core_pkg::ROW_W-1:0] + c8core_pkg::ROW_W'(cnt_reg);

    always_comb
    begin
        spr_mask = '0;
        for (int c = 0; c < 8; c++)
        begin
            col = va_reg[c8core_pkg::COL_W-1:0] + c8core_pkg::COL_W'(c);
            spr_mask[col] = mem_rdata_reg[7-c];
        end
    end

    assign collide = |(frow_reg & spr_mask);

    // loop end detection
    always_comb
    begin
        unique case (op_class)
            c8core_pkg::OPC_DRAW:  cnt_last = (cnt_reg == n - 4'd1);
            c8core_pkg::OPC_BCD:   cnt_last = (cnt_reg == 4'd2);
            default:               cnt_last = (cnt_reg == x);
        endcase
    end

    assign stat.cnt_last   = cnt_last;
    assign stat.cmd        = cmd_reg;
    assign stat.op_class   = op_class;
    assign stat.draw_empty = (n == 4'd0);
    assign stat.clr_last   = (clr_cnt_reg == 12'hFFF);

    // main memory ports
    logic        mem_we;
    logic [11:0] mem_wa;
    logic [7:0]  mem_wd;
    logic [11:0] mem_ra;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = data_reg;
        mem_ra = i_off;
        unique case (cmd.step)
            c8core_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                mem_wd = (clr_cnt_reg < 12'(c8core_pkg::FONT_LEN))
                         ? c8core_pkg::FONT[clr_cnt_reg[6:0]] : 8'd0;
            end
            c8core_pkg::ST_WRITE:    mem_we = 1'b1;
            c8core_pkg::ST_FETCH_HI: mem_ra = pc_reg;
            c8core_pkg::ST_FETCH_LO: mem_ra = pc_reg + 12'd1;
            c8core_pkg::ST_BCD:
            begin
                mem_we = 1'b1;
                mem_wa = i_off;
                mem_wd = bcd_digit;
            end
            c8core_pkg::ST_STR_WR:
            begin
                mem_we = 1'b1;
                mem_wa = i_off;
                mem_wd = va_reg;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            main_mem[mem_wa] <= mem_wd;
        end
        mem_rdata_reg <= main_mem[mem_ra];
    end

    // register file write and read ports
    logic       rf_we;
    logic [3:0] rf_wa;
    logic [7:0] rf_wd;
    logic       rf_re;
    logic [3:0] rf_ra;

    always_comb
    begin
        rf_we = 1'b0;
        rf_wa = x;
        rf_wd = kk;
        if (cmd.step == c8core_pkg::ST_EXEC && !op_invalid)
        begin
            unique case (hi)
                4'h6: rf_we = 1'b1;
                4'h7:
                begin
                    rf_we = 1'b1;
                    rf_wd = va_reg + kk;
                end
                4'h8:
                begin
                    rf_we = 1'b1;
                    if (op_class == c8core_pkg::OPC_ALUF)
                    begin
                        rf_wa = 4'hF;
                        rf_wd = {7'd0, alu_flag};
                    end
                    else
                    begin
                        unique case (n[1:0])
                            2'd0:    rf_wd = vb_reg;
                            2'd1:    rf_wd = va_reg | vb_reg;
                            2'd2:    rf_wd = va_reg & vb_reg;
                            default: rf_wd = va_reg ^ vb_reg;
                        endcase
                    end
                end
                4'hC:
                begin
                    rf_we = 1'b1;
                    rf_wd = rnd_reg & kk;
                end
                4'hF:
                begin
                    if (kk == 8'h07)
                    begin
                        rf_we = 1'b1;
                        rf_wd = delay_reg;
                    end
                    else if (kk == 8'h0A && keys_reg != 16'd0)
                    begin
                        rf_we = 1'b1;
                        rf_wd = {4'd0, last_reg};
                    end
                end
                default: rf_we = 1'b0;
            endcase
        end
        else if (cmd.step == c8core_pkg::ST_ALUWB)
        begin
            rf_we = 1'b1;
            rf_wd = alu_res_reg;
        end
        else if (cmd.step == c8core_pkg::ST_DRAW_END)
        begin
            rf_we = 1'b1;
            rf_wa = 4'hF;
            rf_wd = {7'd0, flag_reg};
        end
        else if (cmd.step == c8core_pkg::ST_LDR_WR)
        begin
            rf_we = 1'b1;
            rf_wa = cnt_reg;
            rf_wd = mem_rdata_reg;
        end
    end

    assign rf_re = (cmd.step == c8core_pkg::ST_REGRD) || (cmd.step == c8core_pkg::ST_STR_RD);
    assign rf_ra = (cmd.step == c8core_pkg::ST_STR_RD) ? cnt_reg
                 : (hi == 4'hB) ? 4'd0 : x;

    // register file storage and registered reads
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
        if (rf_re)
        begin
            va_reg <= rf_valid_reg[rf_ra] ? rf_mem[rf_ra] : 8'd0;
            vb_reg <= rf_valid_reg[y] ? rf_mem[y] : 8'd0;
        end
    end

    // frame rows
    logic [c8core_pkg::ROW_W-1:0] frame_ra;
    logic                         frame_we;

    assign frame_ra = (cmd.step == c8core_pkg::ST_PIXRD) ? addr_reg[10:6] : draw_row;
    assign frame_we = (cmd.step == c8core_pkg::ST_DRAW_WR);

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[draw_row] <= frow_reg ^ spr_mask;
        end
        frow_reg <= fvalid_reg[frame_ra] ? frame_mem[frame_ra] : '0;
    end

    // item latch, payload, opcode, alu result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            addr_reg <= address;
            data_reg <= data;
            keys_reg <= keys_down;
            last_reg <= last_key;
            rnd_reg  <= random_byte;
        end
        if (cmd.step == c8core_pkg::ST_FETCH_LO)
        begin
            op_reg[15:8] <= mem_rdata_reg;
        end
        if (cmd.step == c8core_pkg::ST_OPLAT)
        begin
            op_reg[7:0] <= mem_rdata_reg;
        end
        if (cmd.step == c8core_pkg::ST_EXEC)
        begin
            alu_res_reg <= alu_res;
        end
        if (cmd.step == c8core_pkg::ST_RESULT)
        begin
            status_reg    <= sts_res_reg;
            pc_out_reg    <= pc_reg;
            pixel_reg     <= pix_res_reg;
            drawn_reg     <= drew_res_reg;
            sound_act_reg <= (sound_reg != 8'd0);
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= c8core_pkg::CMD_WRITE;
            pc_reg       <= c8core_pkg::PROG_START;
            index_reg    <= 16'd0;
            sp_reg       <= '0;
            delay_reg    <= 8'd0;
            sound_reg    <= 8'd0;
            flag_reg     <= 1'b0;
            cnt_reg      <= 4'd0;
            clr_cnt_reg  <= 12'd0;
            sts_res_reg  <= c8core_pkg::STS_OK;
            pix_res_reg  <= 1'b0;
            drew_res_reg <= 1'b0;
            rf_valid_reg <= 16'd0;
            fvalid_reg   <= '0;
            for (int k = 0; k < c8core_pkg::STACK_DEPTH; k++)
            begin
                stack_reg[k] <= 12'd0;
            end
        end
        else
        begin
            if (rf_we)
            begin
                rf_valid_reg[rf_wa] <= 1'b1;
            end
            if (frame_we)
            begin
                fvalid_reg[draw_row] <= 1'b1;
            end
            if (cmd.latch)
            begin
                cmd_reg      <= command;
                sts_res_reg  <= c8core_pkg::STS_OK;
                pix_res_reg  <= 1'b0;
                drew_res_reg <= 1'b0;
            end
            unique case (cmd.step)
                c8core_pkg::ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 12'd1;
                end
                c8core_pkg::ST_TICK:
                begin
                    if (delay_reg != 8'd0)
                    begin
                        delay_reg <= delay_reg - 8'd1;
                    end
                    if (sound_reg != 8'd0)
                    begin
                        sound_reg <= sound_reg - 8'd1;
                    end
                end
                c8core_pkg::ST_PIXSEL:
                begin
                    pix_res_reg <= !addr_reg[11] && frow_reg[addr_reg[5:0]];
                end
                c8core_pkg::ST_EXEC:
                begin
                    cnt_reg  <= 4'd0;
                    flag_reg <= 1'b0;
                    if (op_invalid)
                    begin
                        sts_res_reg <= c8core_pkg::STS_INVALID;
                    end
                    else
                    begin
                        pc_reg <= pc_exec;
                        unique case (hi)
                            4'h0:
                            begin
                                if (op_reg == 16'h00E0)
                                begin
                                    fvalid_reg <= '0;
                                end
                                else
                                begin
                                    sp_reg <= sp_dec;
                                end
                            end
                            4'h2:
                            begin
                                stack_reg[sp_reg] <= pc2;
                                sp_reg            <= sp_inc;
                            end
                            4'hA: index_reg <= {4'd0, nnn};
                            4'hD: drew_res_reg <= 1'b1;
                            4'hF:
                            begin
                                unique case (kk)
                                    8'h0A:
                                    begin
                                        if (keys_reg == 16'd0)
                                        begin
                                            sts_res_reg <= c8core_pkg::STS_WAIT;
                                        end
                                    end
                                    8'h15:   delay_reg <= va_reg;
                                    8'h18:   sound_reg <= va_reg;
                                    8'h1E:   index_reg <= index_reg + {8'd0, va_reg};
                                    8'h29:   index_reg <= {12'd0, va_reg[3:0]} * 16'd5;
                                    default: index_reg <= index_reg;
                                endcase
                            end
                            default: index_reg <= index_reg;
                        endcase
                    end
                end
                c8core_pkg::ST_DRAW_WR:
                begin
                    flag_reg <= flag_reg | collide;
                    cnt_reg  <= cnt_reg + 4'd1;
                end
                c8core_pkg::ST_BCD, c8core_pkg::ST_STR_WR, c8core_pkg::ST_LDR_WR:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    assign status          = status_reg;
    assign program_counter = pc_out_reg;
    assign pixel_value     = pixel_reg;
    assign screen_drawn    = drawn_reg;
    assign sound_active    = sound_act_reg;

endmodule

/* test/tb_top.sv */
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] program_counter;
        logic        pixel_value;
        logic        screen_drawn;
        logic        sound_active;
    } core_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keys_down;
    logic [3:0]  last_key;
    logic [7:0]  random_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [11:0] program_counter;
    logic        pixel_value;
    logic        screen_drawn;
    logic        sound_active;

    // shadow machine state
    logic [7:0]  mem_m [4096];
    logic        screen_m [2048];
    logic [11:0] stack_m [c8core_pkg::STACK_DEPTH];
    logic [7:0]  vreg_m [16];
    logic [15:0] index_m;
    logic [11:0] pc_m;
    logic [3:0]  sp_m;
    logic [7:0]  delay_m;
    logic [7:0]  sound_m;

    core_result_t pending_results[$];
    int error_count;
    int sent_count;
    int seen_count;
    int draw_count;
    int invalid_count;
    int burst_left;

    chip8_instruction_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .address         (address),
        .data            (data),
        .keys_down       (keys_down),
        .last_key        (last_key),
        .random_byte     (random_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .program_counter (program_counter),
        .pixel_value     (pixel_value),
        .screen_drawn    (screen_drawn),
        .sound_active    (sound_active)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // shadow state after reset
    task automatic reset_shadow();
        for (int i = 0; i < 4096; i++)
        begin
            mem_m[i] = (i < c8core_pkg::FONT_LEN) ? c8core_pkg::FONT[i] : 8'h00;
        end
        for (int i = 0; i < 2048; i++)
        begin
            screen_m[i] = 1'b0;
        end
        for (int i = 0; i < c8core_pkg::STACK_DEPTH; i++)
        begin
            stack_m[i] = '0;
        end
        for (int i = 0; i < 16; i++)
        begin
            vreg_m[i] = '0;
        end
        index_m = '0;
        pc_m    = c8core_pkg::PROG_START;
        sp_m    = '0;
        delay_m = '0;
        sound_m = '0;
    endtask

    // one instruction on the shadow state; returns the status code
    function automatic logic [1:0] exec_instr(input logic [15:0] keys, input logic [3:0] lk,
                                             input logic [7:0] rnd, output logic drew);
        logic [15:0] op;
        logic [11:0] nxt;
        logic [11:0] nnn;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  kk;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [8:0]  res;
        logic        flag;
        logic        down;
        logic [7:0]  spr;
        int          px;
        int          py;
        logic [1:0]  sts;
        op   = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
        nnn  = op[11:0];
        x    = op[11:8];
        y    = op[7:4];
        n    = op[3:0];
        kk   = op[7:0];
        vx   = vreg_m[x];
        vy   = vreg_m[y];
        nxt  = pc_m + 12'd2;
        sts  = c8core_pkg::STS_OK;
        drew = 1'b0;
        case (op[15:12])
            4'h0:
            begin
                if (op == 16'h00E0)
                begin
                    for (int i = 0; i < 2048; i++)
                    begin
                        screen_m[i] = 1'b0;
                    end
                end
                else if (op == 16'h00EE)
                begin
                    sp_m = sp_m - 4'd1;
                    nxt  = stack_m[sp_m];
                end
                else
                begin
                    return c8core_pkg::STS_INVALID;
                end
            end
            4'h1: nxt = nnn;
            4'h2:
            begin
                stack_m[sp_m] = pc_m + 12'd2;
                sp_m = sp_m + 4'd1;
                nxt  = nnn;
            end
            4'h3: if (vx == kk) nxt = pc_m + 12'd4;
            4'h4: if (vx != kk) nxt = pc_m + 12'd4;
            4'h5: if (vx == vy) nxt = pc_m + 12'd4;
            4'h6: vreg_m[x] = kk;
            4'h7: vreg_m[x] = vx + kk;
            4'h8:
            begin
                case (n)
                    4'h0: vreg_m[x] = vy;
                    4'h1: vreg_m[x] = vx | vy;
                    4'h2: vreg_m[x] = vx & vy;
                    4'h3: vreg_m[x] = vx ^ vy;
                    4'h4, 4'h5, 4'h6, 4'h7, 4'hE:
                    begin
                        case (n)
                            4'h4:
                            begin
                                res  = {1'b0, vx} + {1'b0, vy};
                                flag = res[8];
                            end
                            4'h5:
                            begin
                                res  = {1'b0, vx - vy};
                                flag = vx > vy;
                            end
                            4'h6:
                            begin
                                res  = {2'b0, vx[7:1]};
                                flag = vx[0];
                            end
                            4'h7:
                            begin
                                res  = {1'b0, vy - vx};
                                flag = vy > vx;
                            end
                            default:
                            begin
                                res  = {vx, 1'b0};
                                flag = vx[7];
                            end
                        endcase
                        // flag first, result wins for VF
                        vreg_m[15] = {7'd0, flag};
                        vreg_m[x]  = res[7:0];
                    end
                    default: return c8core_pkg::STS_INVALID;
                endcase
            end
            4'h9: if (vx != vy) nxt = pc_m + 12'd4;
            4'hA: index_m = {4'd0, nnn};
            4'hB: nxt = nnn + {4'd0, vreg_m[0]};
            4'hC: vreg_m[x] = rnd & kk;
            4'hD:
            begin
                flag = 1'b0;
                for (int r = 0; r < n; r++)
                begin
                    spr = mem_m[12'(index_m + r)];
                    py  = (vy + r) % c8core_pkg::ROWS;
                    for (int c = 0; c < 8; c++)
                    begin
                        if (spr[7 - c])
                        begin
                            px = (vx + c) % c8core_pkg::COLS;
                            if (screen_m[px + py * c8core_pkg::COLS])
                            begin
                                flag = 1'b1;
                            end
                            screen_m[px + py * c8core_pkg::COLS] =
                                !screen_m[px + py * c8core_pkg::COLS];
                        end
                    end
                end
                vreg_m[15] = {7'd0, flag};
                drew = 1'b1;
            end
            4'hE:
            begin
                down = (vx < 8'd16) && keys[vx[3:0]];
                if (kk == 8'h9E)
                begin
                    if (down) nxt = pc_m + 12'd4;
                end
                else if (kk == 8'hA1)
                begin
                    if (!down) nxt = pc_m + 12'd4;
                end
                else
                begin
                    return c8core_pkg::STS_INVALID;
                end
            end
            default:
            begin
                case (kk)
                    8'h07: vreg_m[x] = delay_m;
                    8'h0A:
                    begin
                        if (keys == 16'd0)
                        begin
                            nxt = pc_m;
                            sts = c8core_pkg::STS_WAIT;
                        end
                        else
                        begin
                            vreg_m[x] = {4'd0, lk};
                        end
                    end
                    8'h15: delay_m = vx;
                    8'h18: sound_m = vx;
                    8'h1E: index_m = index_m + {8'd0, vx};
                    8'h29: index_m = {12'd0, vx[3:0]} * 16'd5;
                    8'h33:
                    begin
                        mem_m[12'(index_m)]         = vx / 100;
                        mem_m[12'(index_m + 16'd1)] = (vx / 10) % 10;
                        mem_m[12'(index_m + 16'd2)] = vx % 10;
                    end
                    8'h55:
                    begin
                        for (int i = 0; i <= x; i++)
                        begin
                            mem_m[12'(index_m + i)] = vreg_m[i];
                        end
                    end
                    8'h65:
                    begin
                        for (int i = 0; i <= x; i++)
                        begin
                            vreg_m[i] = mem_m[12'(index_m + i)];
                        end
                    end
                    default: return c8core_pkg::STS_INVALID;
                endcase
            end
        endcase
        pc_m = nxt;
        return sts;
    endfunction

    // expected result of one accepted item
    function automatic core_result_t predict_result(input logic [1:0] cmd,
                                                    input logic [11:0] addr,
                                                    input logic [7:0] din,
                                                    input logic [15:0] keys,
                                                    input logic [3:0] lk,
                                                    input logic [7:0] rnd);
        core_result_t exp_r;
        logic drew;
        exp_r = '0;
        case (cmd)
            c8core_pkg::CMD_WRITE: mem_m[addr] = din;
            c8core_pkg::CMD_EXEC:
            begin
                exp_r.status       = exec_instr(keys, lk, rnd, drew);
                exp_r.screen_drawn = drew;
            end
            c8core_pkg::CMD_TICK:
            begin
                if (delay_m != 0) delay_m = delay_m - 8'd1;
                if (sound_m != 0) sound_m = sound_m - 8'd1;
            end
            default: exp_r.pixel_value = (addr < 12'd2048) ? screen_m[addr[10:0]] : 1'b0;
        endcase
        exp_r.program_counter = pc_m;
        exp_r.sound_active    = (sound_m != 0);
        return exp_r;
    endfunction

    // one transfer on the input channel, entered and left at a falling edge
    task automatic send_item(input logic [1:0] cmd, input logic [11:0] addr,
                             input logic [7:0] din, input logic [15:0] keys,
                             input logic [3:0] lk, input logic [7:0] rnd);
        core_result_t exp_r;
        command     = cmd;
        address     = addr;
        data        = din;
        keys_down   = keys;
        last_key    = lk;
        random_byte = rnd;
        in_valid    = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        exp_r = predict_result(cmd, addr, din, keys, lk, rnd);
        if (cmd == c8core_pkg::CMD_EXEC && exp_r.screen_drawn) draw_count++;
        if (cmd == c8core_pkg::CMD_EXEC && exp_r.status == c8core_pkg::STS_INVALID)
            invalid_count++;
        pending_results.push_back(exp_r);
        sent_count++;
        @(negedge clk);
        // bursts with random gaps between them
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
    endtask

    function automatic logic [15:0] random_keys();
        return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    endfunction

    // place an opcode at the predicted pc and run it
    task automatic run_op(input logic [15:0] op, input logic [15:0] keys);
        logic [11:0] at;
        at = pc_m;
        send_item(c8core_pkg::CMD_WRITE, at, op[15:8], 16'($urandom), 4'($urandom),
                  8'($urandom));
        send_item(c8core_pkg::CMD_WRITE, at + 12'd1, op[7:0], 16'($urandom), 4'($urandom),
                  8'($urandom));
        send_item(c8core_pkg::CMD_EXEC, 12'($urandom), 8'($urandom), keys, 4'($urandom),
                  8'($urandom));
    endtask

    function automatic logic [15:0] random_op();
        logic [15:0] op;
        op = 16'($urandom);
        case (op[15:12])
            4'h0:
            begin
                case ($urandom_range(0, 5))
                    0: op = 16'h00E0;
                    1, 2, 3: op = 16'h00EE;
                    default: op = op;
                endcase
            end
            4'h8: if ($urandom_range(0, 7) != 0) op[3:0] = ($urandom_range(0, 8) == 8) ?
                                                          4'hE : 4'($urandom_range(0, 7));
            4'hE: if ($urandom_range(0, 5) != 0) op[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
            4'hF:
            begin
                if ($urandom_range(0, 7) != 0)
                begin
                    case ($urandom_range(0, 8))
                        0: op[7:0] = 8'h07;
                        1: op[7:0] = 8'h0A;
                        2: op[7:0] = 8'h15;
                        3: op[7:0] = 8'h18;
                        4: op[7:0] = 8'h1E;
                        5: op[7:0] = 8'h29;
                        6: op[7:0] = 8'h33;
                        7: op[7:0] = 8'h55;
                        default: op[7:0] = 8'h65;
                    endcase
                end
            end
            default: op = op;
        endcase
        return op;
    endfunction

    // directed: pixel reads, a tick, arithmetic corners, font draw with collision, wait, invalid
    task automatic test_directed();
        send_item(c8core_pkg::CMD_PIXEL, 12'hFFF, 8'hFF, 16'hFFFF, 4'hF, 8'hFF);
        send_item(c8core_pkg::CMD_TICK, 12'h000, 8'h00, 16'h0000, 4'h0, 8'h00);
        run_op(16'h6AFF, 16'h0001);
        run_op(16'h8AA4, 16'h0001);
        run_op(16'h8FA5, 16'h0001);
        run_op(16'hF029, 16'h0001);
        run_op(16'hD005, 16'h0001);
        run_op(16'hD005, 16'h0001);
        run_op(16'hF00A, 16'h0000);
        run_op(16'hE1FF, 16'h0001);
        send_item(c8core_pkg::CMD_PIXEL, 12'h000, 8'h00, 16'h0000, 4'h0, 8'h00);
    endtask

    // random: mostly programs written and run, with ticks, reads and stray writes
    task automatic test_random(input int items);
        int pick;
        while (sent_count < items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                run_op(random_op(), random_keys());
            end
            else if (pick == 7)
            begin
                send_item(c8core_pkg::CMD_TICK, 12'($urandom), 8'($urandom), 16'($urandom),
                          4'($urandom), 8'($urandom));
            end
            else if (pick == 8)
            begin
                send_item(c8core_pkg::CMD_PIXEL, $urandom_range(0, 5) == 0 ? 12'($urandom) :
                          12'($urandom_range(0, 2047)), 8'($urandom), 16'($urandom),
                          4'($urandom), 8'($urandom));
            end
            else
            begin
                send_item(c8core_pkg::CMD_WRITE, 12'($urandom), 8'($urandom), 16'($urandom),
                          4'($urandom), 8'($urandom));
            end
        end
    endtask

    // receiver stall pattern
    int stall_mode;
    int stall_count;
    always @(negedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode  = $urandom_range(0, 2);
            stall_count = $urandom_range(20, 300);
        end
        stall_count--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= (stall_count % 7) < 2;
        endcase
    end

    // compare each transfer on the output channel
    always @(posedge clk)
    begin
        core_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            seen_count++;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: pc %0h", program_counter);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, status);
                    error_count++;
                end
                if (program_counter !== exp_r.program_counter)
                begin
                    $error("program_counter expected %0h actual %0h",
                           exp_r.program_counter, program_counter);
                    error_count++;
                end
                if (pixel_value !== exp_r.pixel_value)
                begin
                    $error("pixel_value expected %0d actual %0d", exp_r.pixel_value, pixel_value);
                    error_count++;
                end
                if (screen_drawn !== exp_r.screen_drawn)
                begin
                    $error("screen_drawn expected %0d actual %0d",
                           exp_r.screen_drawn, screen_drawn);
                    error_count++;
                end
                if (sound_active !== exp_r.sound_active)
                begin
                    $error("sound_active expected %0d actual %0d",
                           exp_r.sound_active, sound_active);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = c8core_pkg::CMD_WRITE;
        address     = '0;
        data        = '0;
        keys_down   = '0;
        last_key    = '0;
        random_byte = '0;
        out_ready   = 1'b0;
        stall_mode  = 0;
        stall_count = 0;
        burst_left  = 0;
        error_count = 0;
        sent_count  = 0;
        seen_count  = 0;
        draw_count  = 0;
        invalid_count = 0;
        reset_shadow();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(1350);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        $display("covered %0d transfers in, %0d results out, %0d draws, %0d invalid opcodes",
                 sent_count, seen_count, draw_count, invalid_count);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
